>>> src/cht_pkg.sv
// Package for the chained hash table: shared codes, the command and status
// structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cht_pkg;
    localparam int KEY_W = 31;
    localparam int VAL_W = 32;
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] RST_BUCKETS = 5'd10;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_SEARCH = 2'd2,
        FN_NOP    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic    clr_step;
        logic    accept;
        logic    div_step;
        logic    rd_head;
        logic    ins_commit;
        logic    walk_init;
        logic    rd_node;
        logic    walk_adv;
        logic    unlink;
        logic    free_push;
        logic    set_res;
        t_status res_status;
        logic    res_found;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic is_insert;
        logic is_walk;
        logic is_remove;
        logic pool_empty;
        logic walk_end;
        logic hit;
        logic out_free;
    } t_sts;
endpackage
`default_nettype wire

>>> src/cht_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface cht_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [30:0] key;
    logic signed [31:0] value;
    modport source (output valid, func, key, value, input ready);
    modport sink (input valid, func, key, value, output ready);
endinterface

interface cht_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [31:0] found_value;
    modport source (output valid, status, found_value, input ready);
    modport sink (input valid, status, found_value, output ready);
endinterface
`default_nettype wire

>>> src/chained_hash_table.sv
// Hash table with separate chaining: one request at a time, one response each.
// Steps from accept to response valid: bit-serial key modulo, bucket head read, then
// response load for insert or no-op; search and remove first read each chain node
// visited, find a miss at the chain end, and on a remove hit free the node as well.
// A new request is taken only once the response of the last one is loaded.
// Reset: synchronous; then a clearing pass over heads and links, ready low meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_table
    import cht_pkg::*;
#(
    parameter int MAX_BUCKETS = 16,
    parameter int POOL_DEPTH  = 64
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [CNT_W-1:0]  i_cfg_wdata,
    cht_req_if.sink          i_req,
    cht_rsp_if.source        o_rsp
);
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    assign i_req.ready = w_ready;

    cht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    cht_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .POOL_DEPTH  (POOL_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_func        (i_req.func),
        .i_key         (i_req.key),
        .i_value       (i_req.value),
        .o_valid       (o_rsp.valid),
        .i_ready       (o_rsp.ready),
        .o_status      (o_rsp.status),
        .o_found_value (o_rsp.found_value)
    );
endmodule
`default_nettype wire

>>> src/cht_ctrl.sv
// Controller state machine of the hash table: sequences clear, hash, chain
// walk and response. Depends on cht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cht_ctrl
    import cht_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_req_valid,
    output logic  o_req_ready,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);
    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_HEAD  = 9'b000001000,
        S_HWAIT = 9'b000010000,
        S_NREAD = 9'b000100000,
        S_NCHK  = 9'b001000000,
        S_FREE  = 9'b010000000,
        S_RESP  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_status = ST_OK;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.rd_head = 1'b1;
                n_state = S_HWAIT;
            end
            S_HWAIT: begin
                if (i_sts.is_insert) begin
                    o_cmd.set_res = 1'b1;
                    if (i_sts.pool_empty) begin
                        o_cmd.res_status = ST_FULL;
                    end else begin
                        o_cmd.ins_commit = 1'b1;
                    end
                    n_state = S_RESP;
                end else if (i_sts.is_walk) begin
                    o_cmd.walk_init = 1'b1;
                    n_state = S_NREAD;
                end else begin
                    o_cmd.set_res = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_NREAD: begin
                if (i_sts.walk_end) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_MISS;
                    n_state = S_RESP;
                end else begin
                    o_cmd.rd_node = 1'b1;
                    n_state = S_NCHK;
                end
            end
            S_NCHK: begin
                if (i_sts.hit) begin
                    o_cmd.set_res = 1'b1;
                    if (i_sts.is_remove) begin
                        o_cmd.unlink = 1'b1;
                        n_state = S_FREE;
                    end else begin
                        o_cmd.res_found = 1'b1;
                        n_state = S_RESP;
                    end
                end else begin
                    o_cmd.walk_adv = 1'b1;
                    n_state = S_NREAD;
                end
            end
            S_FREE: begin
                o_cmd.free_push = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                // hold until the output register can take the word
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> src/cht_dp.sv
// Datapath of the hash table: bucket and node memories, bit-serial modulo,
// walk registers, free list head and output register. Depends on cht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cht_dp
    import cht_pkg::*;
#(
    parameter int MAX_BUCKETS = 16,
    parameter int POOL_DEPTH  = 64
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  wire                   i_cfg_we,
    input  wire [CNT_W-1:0]       i_cfg_wdata,
    input  wire [1:0]             i_func,
    input  wire [KEY_W-1:0]       i_key,
    input  wire [VAL_W-1:0]       i_value,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic [1:0]            o_status,
    output logic [VAL_W-1:0]      o_found_value
);
    localparam int HW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int AW    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int LW    = $clog2(POOL_DEPTH + 1);
    localparam int CLR_N = (MAX_BUCKETS > POOL_DEPTH) ? MAX_BUCKETS : POOL_DEPTH;
    localparam int CW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);

    logic [CNT_W-1:0] r_cfg;
    logic [1:0]       r_func;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_div_cnt;
    logic [LW-1:0]    r_free_head, r_cur, r_prev, r_steps;
    logic [CW-1:0]    r_clr_idx;
    t_status          r_res_status;
    logic [VAL_W-1:0] r_res_val;

    logic [LW-1:0]    m_head [MAX_BUCKETS];
    logic [LW-1:0]    m_next [POOL_DEPTH];
    logic [KEY_W-1:0] m_key  [POOL_DEPTH];
    logic [VAL_W-1:0] m_val  [POOL_DEPTH];
    logic [LW-1:0]    r_head_rd, r_next_rd;
    logic [KEY_W-1:0] r_key_rd;
    logic [VAL_W-1:0] r_val_rd;

    logic [CNT_W-1:0] w_div;
    logic [CNT_W:0]   w_trial;
    logic [HW-1:0]    w_bkt;
    logic             w_clr_head, w_clr_next;

    // effective divisor: zero acts as one, saturate at the bucket array size
    always_comb begin
        if (r_cfg == '0) begin
            w_div = CNT_W'(1);
        end else if (32'(r_cfg) > MAX_BUCKETS) begin
            w_div = CNT_W'(MAX_BUCKETS);
        end else begin
            w_div = r_cfg;
        end
        w_trial = {r_rem, r_key[r_div_cnt]};
        if (w_trial >= {1'b0, w_div}) w_trial = w_trial - {1'b0, w_div};
    end

    assign w_bkt      = HW'(r_rem);
    assign w_clr_head = i_cmd.clr_step && (32'(r_clr_idx) < MAX_BUCKETS);
    assign w_clr_next = i_cmd.clr_step && (32'(r_clr_idx) < POOL_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= RST_BUCKETS;
            r_clr_idx   <= '0;
            r_free_head <= '0;
            o_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (i_cmd.clr_step) r_clr_idx <= r_clr_idx + CW'(1);
            if (i_cmd.ins_commit) r_free_head <= r_next_rd;
            if (i_cmd.free_push) r_free_head <= r_cur;
            if (i_cmd.out_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func    <= i_func;
            r_key     <= i_key;
            r_value   <= i_value;
            r_rem     <= '0;
            r_div_cnt <= CNT_W'(KEY_W - 1);
        end
        if (i_cmd.div_step) begin
            r_rem     <= w_trial[CNT_W-1:0];
            r_div_cnt <= r_div_cnt - CNT_W'(1);
        end
        if (i_cmd.walk_init) begin
            r_cur   <= r_head_rd;
            r_prev  <= NULL_LINK;
            r_steps <= '0;
        end
        if (i_cmd.walk_adv) begin
            r_prev  <= r_cur;
            r_cur   <= r_next_rd;
            r_steps <= r_steps + LW'(1);
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            r_res_val    <= i_cmd.res_found ? r_val_rd : '0;
        end
        if (i_cmd.out_load) begin
            o_status      <= r_res_status;
            o_found_value <= r_res_val;
        end
    end

    // bucket head memory
    always_ff @(posedge i_clk) begin
        if (w_clr_head) begin
            m_head[HW'(r_clr_idx)] <= NULL_LINK;
        end else if (i_cmd.ins_commit) begin
            m_head[w_bkt] <= r_free_head;
        end else if (i_cmd.unlink && r_prev == NULL_LINK) begin
            m_head[w_bkt] <= r_next_rd;
        end
        if (i_cmd.rd_head) r_head_rd <= m_head[w_bkt];
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (w_clr_next) begin
            m_next[AW'(r_clr_idx)] <= LW'(32'(r_clr_idx) + 1);
        end else if (i_cmd.ins_commit) begin
            m_next[AW'(r_free_head)] <= r_head_rd;
        end else if (i_cmd.unlink && r_prev != NULL_LINK) begin
            m_next[AW'(r_prev)] <= r_next_rd;
        end else if (i_cmd.free_push) begin
            m_next[AW'(r_cur)] <= r_free_head;
        end
        if (i_cmd.rd_head) begin
            r_next_rd <= m_next[AW'(r_free_head)];
        end else if (i_cmd.rd_node) begin
            r_next_rd <= m_next[AW'(r_cur)];
        end
    end

    // key and value memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_commit) begin
            m_key[AW'(r_free_head)] <= r_key;
            m_val[AW'(r_free_head)] <= r_value;
        end
        if (i_cmd.rd_node) begin
            r_key_rd <= m_key[AW'(r_cur)];
            r_val_rd <= m_val[AW'(r_cur)];
        end
    end

    always_comb begin
        o_sts.clr_done   = (32'(r_clr_idx) == CLR_N - 1);
        o_sts.div_done   = (r_div_cnt == '0);
        o_sts.is_insert  = (r_func == FN_INSERT);
        o_sts.is_walk    = (r_func == FN_REMOVE) || (r_func == FN_SEARCH);
        o_sts.is_remove  = (r_func == FN_REMOVE);
        o_sts.pool_empty = (r_free_head == NULL_LINK);
        o_sts.walk_end   = (r_cur == NULL_LINK) || (r_steps == LW'(POOL_DEPTH));
        o_sts.hit        = (r_key_rd == r_key);
        o_sts.out_free   = !o_valid || i_ready;
    end
endmodule
`default_nettype wire

>>> src/cht_checker.sv
// Port-level checker for the hash table, bound to the top level.
// Depends on chained_hash_table ports only.
`timescale 1ns / 1ps
`default_nettype none
module cht_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [1:0]  i_status,
    input wire [31:0] i_found
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status != 2'd3)
        else $error("undefined status code");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != 2'd0 |-> i_found == 32'd0)
        else $error("value returned on failed request");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("request taken during clearing pass");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while busy");
endmodule

bind chained_hash_table cht_checker u_cht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_found     (o_rsp.found_value)
);
`default_nettype wire
